FILE: sv/assert_macros.svh
// Assertion helpers for the RTL files; fcbf_ctrl.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define FCBF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every rising clock edge, reset included.
`define FCBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: sv/fcbf_pkg.sv
`timescale 1ns / 1ps

package fcbf_pkg;

    localparam int unsigned BUFFER_DEPTH_DEF = 1024;
    localparam int unsigned CAP_W            = 11;
    localparam int unsigned TOT_W            = 48;
    localparam logic [CAP_W-1:0] CAP_RESET   = 11'd1024;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_PEEK  = 2'd1,
        OP_POP   = 2'd2,
        OP_END   = 2'd3
    } t_op;

    typedef struct packed {
        logic             write_accepted;
        logic             read_valid;
        logic [CAP_W-1:0] fill_level;
        logic [CAP_W-1:0] space_left;
        logic             input_closed;
        logic             stream_done;
        logic [TOT_W-1:0] total_written;
        logic [TOT_W-1:0] total_read;
    } t_status;

endpackage

FILE: sv/fcbf_store.sv
`timescale 1ns / 1ps

module fcbf_store #(
    parameter int unsigned DEPTH = fcbf_pkg::BUFFER_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    import fcbf_pkg::*;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds between peeks so a stalled result keeps its byte.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/fcbf_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fcbf_ctrl #(
    parameter int unsigned DEPTH = fcbf_pkg::BUFFER_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [fcbf_pkg::CAP_W-1:0] i_cfg_wdata,
    input  logic                       i_fire,
    input  fcbf_pkg::t_op              i_op,
    input  logic [fcbf_pkg::CAP_W-1:0] i_amount,
    output logic                       o_we,
    output logic [AW-1:0]              o_waddr,
    output logic                       o_re,
    output logic [AW-1:0]              o_raddr,
    output fcbf_pkg::t_status          o_status
);
    import fcbf_pkg::*;

    localparam int unsigned SW = ((AW > CAP_W) ? AW : CAP_W) + 1;
    localparam logic [CAP_W-1:0] DEPTH_SAT =
        (DEPTH > 2047) ? 11'd2047 : CAP_W'(DEPTH);

    function automatic logic [CAP_W-1:0] sat_cap(input logic [CAP_W-1:0] cap);
        return (cap > DEPTH_SAT) ? DEPTH_SAT : cap;
    endfunction

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] head,
                                           input logic [CAP_W-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [CAP_W-1:0] room(input logic [CAP_W-1:0] cap,
                                              input logic [CAP_W-1:0] held);
        return (cap > held) ? (cap - held) : '0;
    endfunction

    logic [AW-1:0]    r_head,   n_head;
    logic [CAP_W-1:0] r_held,   n_held;
    logic             r_closed, n_closed;
    logic [TOT_W-1:0] r_tw,     n_tw;
    logic [TOT_W-1:0] r_tr,     n_tr;
    logic [CAP_W-1:0] r_eff_cap;
    logic [CAP_W-1:0] pop_n;
    logic [CAP_W-1:0] space_now;
    logic             v_acc;
    logic             v_rvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_held    <= '0;
            r_closed  <= 1'b0;
            r_tw      <= '0;
            r_tr      <= '0;
            r_eff_cap <= sat_cap(CAP_RESET);
        end else begin
            r_head   <= n_head;
            r_held   <= n_held;
            r_closed <= n_closed;
            r_tw     <= n_tw;
            r_tr     <= n_tr;
            if (i_cfg_we) begin
                r_eff_cap <= sat_cap(i_cfg_wdata);
            end
        end
    end

    // A byte written in one cycle is in the store by the next, so a peek
    // right behind a write reads it without forwarding.
    always_comb begin
        n_head    = r_head;
        n_held    = r_held;
        n_closed  = r_closed;
        n_tw      = r_tw;
        n_tr      = r_tr;
        o_we      = 1'b0;
        o_re      = 1'b0;
        v_acc     = 1'b0;
        v_rvalid  = 1'b0;
        o_waddr   = wrap(r_head, r_held);
        o_raddr   = wrap(r_head, i_amount);
        pop_n     = (i_amount < r_held) ? i_amount : r_held;
        space_now = room(r_eff_cap, r_held);
        if (i_fire) begin
            unique case (i_op)
                OP_WRITE: begin
                    if (!r_closed && space_now != '0) begin
                        o_we   = 1'b1;
                        v_acc  = 1'b1;
                        n_held = r_held + 11'd1;
                        n_tw   = r_tw + 48'd1;
                    end
                end
                OP_PEEK: begin
                    if (i_amount < r_held) begin
                        o_re     = 1'b1;
                        v_rvalid = 1'b1;
                    end
                end
                OP_POP: begin
                    n_head = wrap(r_head, pop_n);
                    n_held = r_held - pop_n;
                    n_tr   = r_tr + TOT_W'(pop_n);
                end
                OP_END: begin
                    n_closed = 1'b1;
                end
            endcase
        end
        o_status.write_accepted = v_acc;
        o_status.read_valid     = v_rvalid;
        o_status.fill_level     = n_held;
        o_status.space_left     = room(r_eff_cap, n_held);
        o_status.input_closed   = n_closed;
        o_status.stream_done    = n_closed && (n_held == '0);
        o_status.total_written  = n_tw;
        o_status.total_read     = n_tr;
    end

    `FCBF_ASSERT(a_held_bound, i_clk, i_rst_n, r_held <= DEPTH_SAT, "fill above store size")
    `FCBF_ASSERT(a_closed_sticky, i_clk, i_rst_n, r_closed |=> r_closed, "closed flag cleared")
    `FCBF_ASSERT(a_no_write_closed, i_clk, i_rst_n, (i_fire && r_closed) |-> !o_we, "write after end")

endmodule

FILE: sv/flow_controlled_byte_fifo_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                          Payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tuser: operation; tdata: byte, amount
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata: one status result
// cfg       in   i_cfg_we                           i_cfg_wdata: capacity_bytes
//
// One request per cycle while the output is not stalled; each yields one result in the cycle after it is accepted.
// A peek byte comes from the store's registered read port alongside the result register.
// A new request is taken while the last result is being taken, so a stalled
// output holds the input off only while its result waits.
// Reset clears pointers, fill, flags and totals; the byte store is not cleared.
module flow_controlled_byte_fifo_unit #(
    parameter int unsigned BUFFER_DEPTH = fcbf_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [fcbf_pkg::CAP_W-1:0] i_cfg_wdata,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [7:0] data_byte, [18:8] amount, [23:19] zero
    input  logic [23:0]                i_s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]                 i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // [0] write_accepted, [1] read_valid, [9:2] read_byte, [20:10] fill_level,
    // [31:21] space_left, [32] input_closed, [33] stream_done,
    // [81:34] total_written, [129:82] total_read, [135:130] zero
    output logic [135:0]               o_m_axis_tdata
);
    import fcbf_pkg::*;

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);

    logic          fire;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    t_status       next_status;
    t_status       r_status;
    logic          r_out_valid;
    logic [7:0]    read_byte;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign fire            = i_s_axis_tvalid && o_s_axis_tready;

    fcbf_ctrl #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_op        (t_op'(i_s_axis_tuser)),
        .i_amount    (i_s_axis_tdata[18:8]),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_re        (mem_re),
        .o_raddr     (mem_raddr),
        .o_status    (next_status)
    );

    fcbf_store #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_s_axis_tdata[7:0]),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= next_status;
        end
    end

    // Drop the stale store byte when the peek missed or no peek was made.
    assign read_byte = r_status.read_valid ? mem_rdata : 8'd0;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0,
                              r_status.total_read,
                              r_status.total_written,
                              r_status.stream_done,
                              r_status.input_closed,
                              r_status.space_left,
                              r_status.fill_level,
                              read_byte,
                              r_status.read_valid,
                              r_status.write_accepted};

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import fcbf_pkg::*;

    localparam int DEPTH       = BUFFER_DEPTH_DEF;
    localparam int IDLE_PCT    = 34;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_ITEMS = 80;
    localparam int PEND_SLOTS  = 16;
    localparam int MAX_ROWS    = 32;

    // Bit layout of o_m_axis_tdata, highest field first
    typedef struct packed {
        logic [5:0]       pad;
        logic [TOT_W-1:0] total_read;
        logic [TOT_W-1:0] total_written;
        logic             stream_done;
        logic             input_closed;
        logic [CAP_W-1:0] space_left;
        logic [CAP_W-1:0] fill_level;
        logic [7:0]       read_byte;
        logic             read_valid;
        logic             write_accepted;
    } t_status_word;

    // Status fields typed into a directed row; totals always come from the predictor
    typedef struct packed {
        logic             acc;
        logic             vld;
        logic [7:0]       rbyte;
        logic [CAP_W-1:0] fill;
        logic [CAP_W-1:0] space;
        logic             closed;
        logic             done;
    } t_status_pin;

    typedef struct packed {
        t_op              op;
        logic [7:0]       data;
        logic [CAP_W-1:0] amount;
        logic             set_cap;
        logic [CAP_W-1:0] cap;
        logic             pinned;
        t_status_pin      pin;
    } t_stim_row;

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_cfg_we        = 1'b0;
    logic [CAP_W-1:0] i_cfg_wdata     = '0;
    logic             i_s_axis_tvalid = 1'b0;
    wire              o_s_axis_tready;
    // [7:0] data_byte, [18:8] amount, [23:19] zero
    logic [23:0]      i_s_axis_tdata  = '0;
    // [1:0] operation
    logic [1:0]       i_s_axis_tuser  = '0;
    wire              o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    // [0] write_accepted, [1] read_valid, [9:2] read_byte, [20:10] fill_level,
    // [31:21] space_left, [32] input_closed, [33] stream_done,
    // [81:34] total_written, [129:82] total_read, [135:130] zero
    wire [135:0]      o_m_axis_tdata;

    flow_controlled_byte_fifo_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Shadow copy of the buffer, its pointers, flags, totals and capacity
    logic [7:0]       shadow_bytes [DEPTH];
    int unsigned      shadow_head    = 0;
    int unsigned      shadow_fill    = 0;
    bit               shadow_closed  = 1'b0;
    logic [TOT_W-1:0] shadow_written = '0;
    logic [TOT_W-1:0] shadow_read    = '0;
    logic [CAP_W-1:0] shadow_cap     = CAP_RESET;

    // Ring of expected results, filled on request accept, drained on result accept
    t_status_word pending_status [PEND_SLOTS];
    int           pend_wr        = 0;
    int           pend_rd        = 0;
    t_stim_row    directed_rows [MAX_ROWS];
    int           row_count      = 0;
    int           mismatch_count = 0;
    bit           idle_enabled   = 1'b1;
    int           hold_requests  = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned room_left();
        int unsigned eff;
        eff = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
        return (eff > shadow_fill) ? eff - shadow_fill : 0;
    endfunction

    function automatic t_status_word predict_status(t_op op, logic [7:0] data,
                                                    logic [CAP_W-1:0] amount);
        t_status_word s;
        int unsigned  n;
        s = '0;
        case (op)
            OP_WRITE: begin
                if (!shadow_closed && room_left() > 0) begin
                    shadow_bytes[(shadow_head + shadow_fill) % DEPTH] = data;
                    shadow_fill++;
                    shadow_written = shadow_written + 1'b1;
                    s.write_accepted = 1'b1;
                end
            end
            OP_PEEK: begin
                if (amount < shadow_fill) begin
                    s.read_valid = 1'b1;
                    s.read_byte  = shadow_bytes[(shadow_head + amount) % DEPTH];
                end
            end
            OP_POP: begin
                n = (amount < shadow_fill) ? amount : shadow_fill;
                shadow_head = (shadow_head + n) % DEPTH;
                shadow_fill -= n;
                shadow_read = shadow_read + TOT_W'(n);
            end
            OP_END: begin
                shadow_closed = 1'b1;
            end
        endcase
        s.fill_level    = CAP_W'(shadow_fill);
        s.space_left    = CAP_W'(room_left());
        s.input_closed  = shadow_closed;
        s.stream_done   = shadow_closed && (shadow_fill == 0);
        s.total_written = shadow_written;
        s.total_read    = shadow_read;
        return s;
    endfunction

    function automatic t_status_pin typed_status(logic acc, logic vld, logic [7:0] rbyte,
                                                 logic [CAP_W-1:0] fill,
                                                 logic [CAP_W-1:0] space,
                                                 logic closed, logic done);
        return {acc, vld, rbyte, fill, space, closed, done};
    endfunction

    function automatic t_stim_row plan(t_op op, logic [7:0] data, logic [CAP_W-1:0] amount,
                                       logic set_cap, logic [CAP_W-1:0] cap,
                                       logic pinned, t_status_pin pin);
        return {op, data, amount, set_cap, cap, pinned, pin};
    endfunction

    task automatic add_row(t_stim_row row);
        directed_rows[row_count] = row;
        row_count++;
    endtask

    task automatic send_item(t_op op, logic [7:0] data, logic [CAP_W-1:0] amount,
                             logic pinned, t_status_pin pin);
        t_status_word s;
        while (idle_enabled && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {5'd0, amount, data};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        s = predict_status(op, data, amount);
        if (pinned) begin
            s.write_accepted = pin.acc;
            s.read_valid     = pin.vld;
            s.read_byte      = pin.rbyte;
            s.fill_level     = pin.fill;
            s.space_left     = pin.space;
            s.input_closed   = pin.closed;
            s.stream_done    = pin.done;
        end
        pending_status[pend_wr % PEND_SLOTS] = s;
        pend_wr++;
    endtask

    // Drop valid and hold until every outstanding request has its result
    task automatic settle_input();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pend_wr != pend_rd) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        settle_input();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shadow_cap = value;
    endtask

    task automatic run_rows(int first, int last);
        for (int k = first; k < last; k++) begin
            if (directed_rows[k].set_cap) write_capacity(directed_rows[k].cap);
            send_item(directed_rows[k].op, directed_rows[k].data, directed_rows[k].amount,
                      directed_rows[k].pinned, directed_rows[k].pin);
        end
    endtask

    task automatic send_random(int write_pct, bit allow_end);
        int               r;
        t_op              op;
        logic [CAP_W-1:0] amt;
        r   = $urandom_range(0, 99);
        amt = CAP_W'($urandom_range(0, 2047));
        if (r < write_pct) begin
            op = OP_WRITE;
        end else if (r < write_pct + (100 - write_pct) / 2) begin
            op = OP_PEEK;
            // mostly aim within or just past the fill level
            if ($urandom_range(0, 4) != 0) amt = CAP_W'($urandom_range(0, shadow_fill + 1));
        end else begin
            op = OP_POP;
            r  = $urandom_range(0, 9);
            if (r < 7) amt = CAP_W'($urandom_range(0, 4));
            else if (r < 9) amt = CAP_W'($urandom_range(0, 32));
        end
        if (allow_end && $urandom_range(0, 9) == 0) op = OP_END;
        send_item(op, 8'($urandom_range(0, 255)), amt, 1'b0, '0);
    endtask

    task automatic compare_field(string name, logic [TOT_W-1:0] want, logic [TOT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    initial begin : result_checker
        t_status_word got;
        t_status_word want;
        int           hold_left;
        int           holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                if (pend_wr == pend_rd) begin
                    $error("result with no request outstanding: %h", o_m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_status[pend_rd % PEND_SLOTS];
                    pend_rd++;
                    compare_field("write_accepted", TOT_W'(want.write_accepted),
                                  TOT_W'(got.write_accepted));
                    compare_field("read_valid", TOT_W'(want.read_valid),
                                  TOT_W'(got.read_valid));
                    compare_field("read_byte", TOT_W'(want.read_byte),
                                  TOT_W'(got.read_byte));
                    compare_field("fill_level", TOT_W'(want.fill_level),
                                  TOT_W'(got.fill_level));
                    compare_field("space_left", TOT_W'(want.space_left),
                                  TOT_W'(got.space_left));
                    compare_field("input_closed", TOT_W'(want.input_closed),
                                  TOT_W'(got.input_closed));
                    compare_field("stream_done", TOT_W'(want.stream_done),
                                  TOT_W'(got.stream_done));
                    compare_field("total_written", want.total_written, got.total_written);
                    compare_field("total_read", want.total_read, got.total_read);
                end
            end
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= !idle_enabled || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("flow_controlled_byte_fifo_unit regression: fail");
        $finish;
    end

    initial begin : stimulus
        int               open_rows;
        int               write_pct;
        logic [CAP_W-1:0] phase_cap [7];

        // Empty buffer, extremes of offset and count, capacity 1, 0 and above depth
        add_row(plan(OP_PEEK, 8'h00, 0, 0, 0, 1,
                     typed_status(0, 0, 8'h00, 0, 1024, 0, 0)));
        add_row(plan(OP_POP, 8'h00, 0, 0, 0, 1,
                     typed_status(0, 0, 8'h00, 0, 1024, 0, 0)));
        add_row(plan(OP_WRITE, 8'hFF, 0, 0, 0, 1,
                     typed_status(1, 0, 8'h00, 1, 1023, 0, 0)));
        add_row(plan(OP_WRITE, 8'h00, 11'd2047, 0, 0, 1,
                     typed_status(1, 0, 8'h00, 2, 1022, 0, 0)));
        add_row(plan(OP_POP, 8'h00, 0, 0, 0, 1,
                     typed_status(0, 0, 8'h00, 2, 1022, 0, 0)));
        add_row(plan(OP_PEEK, 8'h00, 0, 0, 0, 1,
                     typed_status(0, 1, 8'hFF, 2, 1022, 0, 0)));
        add_row(plan(OP_PEEK, 8'hFF, 1, 0, 0, 1,
                     typed_status(0, 1, 8'h00, 2, 1022, 0, 0)));
        add_row(plan(OP_PEEK, 8'h00, 2, 0, 0, 1,
                     typed_status(0, 0, 8'h00, 2, 1022, 0, 0)));
        add_row(plan(OP_PEEK, 8'h00, 11'd2047, 0, 0, 1,
                     typed_status(0, 0, 8'h00, 2, 1022, 0, 0)));
        add_row(plan(OP_POP, 8'h00, 11'd2047, 0, 0, 1,
                     typed_status(0, 0, 8'h00, 0, 1024, 0, 0)));
        add_row(plan(OP_WRITE, 8'hA5, 0, 1, 11'd1, 1,
                     typed_status(1, 0, 8'h00, 1, 0, 0, 0)));
        add_row(plan(OP_WRITE, 8'h5A, 0, 0, 0, 1,
                     typed_status(0, 0, 8'h00, 1, 0, 0, 0)));
        add_row(plan(OP_WRITE, 8'h33, 0, 1, 11'd0, 1,
                     typed_status(0, 0, 8'h00, 1, 0, 0, 0)));
        add_row(plan(OP_PEEK, 8'h00, 0, 0, 0, 1,
                     typed_status(0, 1, 8'hA5, 1, 0, 0, 0)));
        add_row(plan(OP_POP, 8'h00, 1, 0, 0, 1,
                     typed_status(0, 0, 8'h00, 0, 0, 0, 0)));
        add_row(plan(OP_WRITE, 8'h80, 0, 1, 11'd2047, 1,
                     typed_status(1, 0, 8'h00, 1, 1023, 0, 0)));
        add_row(plan(OP_WRITE, 8'h7F, 0, 0, 0, 0, '0));
        add_row(plan(OP_POP, 8'h00, 2, 0, 0, 0, '0));
        open_rows = row_count;
        // Closing rows: end of input is final, so they run after the random part
        add_row(plan(OP_POP, 8'h00, 11'd2047, 1, 11'd1024, 1,
                     typed_status(0, 0, 8'h00, 0, 1024, 0, 0)));
        add_row(plan(OP_WRITE, 8'h6C, 0, 0, 0, 1,
                     typed_status(1, 0, 8'h00, 1, 1023, 0, 0)));
        add_row(plan(OP_WRITE, 8'h93, 0, 0, 0, 0, '0));
        add_row(plan(OP_END, 8'h00, 0, 0, 0, 1,
                     typed_status(0, 0, 8'h00, 2, 1022, 1, 0)));
        add_row(plan(OP_WRITE, 8'h01, 0, 0, 0, 1,
                     typed_status(0, 0, 8'h00, 2, 1022, 1, 0)));
        add_row(plan(OP_PEEK, 8'h00, 1, 0, 0, 1,
                     typed_status(0, 1, 8'h93, 2, 1022, 1, 0)));
        add_row(plan(OP_POP, 8'h00, 1, 0, 0, 1,
                     typed_status(0, 0, 8'h00, 1, 1023, 1, 0)));
        add_row(plan(OP_END, 8'h00, 0, 0, 0, 1,
                     typed_status(0, 0, 8'h00, 1, 1023, 1, 0)));
        add_row(plan(OP_POP, 8'h00, 11'd1024, 0, 0, 1,
                     typed_status(0, 0, 8'h00, 0, 1024, 1, 1)));

        phase_cap[0] = 11'd16;
        phase_cap[1] = 11'd1024;
        phase_cap[2] = 11'd2047;
        phase_cap[3] = CAP_W'($urandom_range(1, 1024));
        phase_cap[4] = 11'd0;
        phase_cap[5] = 11'd5;
        phase_cap[6] = CAP_W'($urandom_range(0, 2047));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_rows(0, open_rows);

        for (int phase = 0; phase < 7; phase++) begin
            write_capacity(phase_cap[phase]);
            write_pct    = (phase == 3) ? 80 : $urandom_range(35, 75);
            idle_enabled = (phase != 2);
            // stall the result side while requests keep coming
            if (phase == 3) hold_requests++;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (phase == 5 && i == PHASE_ITEMS / 2) settle_input();
                send_random(write_pct, 1'b0);
            end
        end
        idle_enabled = 1'b1;

        run_rows(open_rows, row_count);
        repeat (20) send_random(40, 1'b1);

        settle_input();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("flow_controlled_byte_fifo_unit regression: pass");
        else
            $display("flow_controlled_byte_fifo_unit regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/fcbf_pkg.sv
sv/fcbf_store.sv
sv/fcbf_ctrl.sv
sv/flow_controlled_byte_fifo_unit.sv
test/tb_top.sv
